// ===== hdl/bfl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfl_pkg - shared types and constants for the bf16 table evaluator
// Transaction payloads, mode codes and table geometry.
// ----------------------------------------------------------------------------
package bfl_pkg;

	localparam int TableEntriesDef = 256;
	localparam int ExpPosBase      = 62 + 1;
	localparam int ExpNegBase      = 62 + 129;
	localparam logic [7:0] MantIndexMask = 8'hff;
	localparam logic [15:0] Bf16Qnan = 16'h7fc0;
	localparam logic [15:0] Bf16Inf  = 16'h7f80;

	typedef enum logic [1:0] {
		MODE_COMPUTE   = 2'd0,
		MODE_WR_EXP    = 2'd1,
		MODE_WR_MANT   = 2'd2,
		MODE_RSVD      = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  index;
		logic [15:0] value;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] result;
		logic        last_out;
	} out_item_t;

endpackage

// ===== hdl/bfl_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfl_stream_if - valid/ready channel
// Carries one payload per transaction.
// ----------------------------------------------------------------------------
interface bfl_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/bf16_exponent_mantissa_lut_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_exponent_mantissa_lut_top - bf16 function evaluator from two tables
// Table load items and compute items share one input channel.
// ----------------------------------------------------------------------------
// One transaction per cycle is accepted when the output side keeps up. Write
// items update a table in the cycle after acceptance and give no result;
// compute items reach the output after five register stages (index decode,
// table read, 8x8 multiply, normalise/round, output). The pipeline advances
// as a whole; the output register is the last stage, so a result waiting to
// be taken only stalls the pipe once that stage is full. Table contents are
// undefined until written; no clearing pass.
module bf16_exponent_mantissa_lut_top #(
	parameter int TABLE_ENTRIES = bfl_pkg::TableEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	bfl_stream_if.sink   in_ch,
	bfl_stream_if.source out_ch
);
	import bfl_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	assign adv = !v_s5 || out_ch.ready;
	assign in_ch.ready = adv;

	in_item_t it;
	assign it = in_ch.data;
	logic acc;
	assign acc = in_ch.valid && adv;

	logic [15:0] exp_mem [TABLE_ENTRIES];
	logic [15:0] mant_mem [TABLE_ENTRIES];

	// stage 1: decode
	logic [IW-1:0] ei_c, ei_s1, mi_s1;
	logic          last_s1;
	logic [7:0]    ef;
	logic signed [9:0] e_c;
	always_comb begin
		ef = it.value[14:7];
		e_c = (ef == 8'd0) ? -10'sd127 : ($signed({2'b00, ef}) - 10'sd127);
		if (e_c < -10'sd62) e_c = -10'sd62;
		if (e_c > 10'sd64) e_c = 10'sd64;
		if (it.value[14:0] == 15'd0) ei_c = '0;
		else if (it.value[15]) ei_c = IW'(e_c + 10'(ExpNegBase));
		else ei_c = IW'(e_c + 10'(ExpPosBase));
	end

	always_ff @(posedge clk) begin
		if (acc && mode_t'(it.mode) == MODE_WR_EXP) exp_mem[it.index[IW-1:0]] <= it.value;
		if (acc && mode_t'(it.mode) == MODE_WR_MANT) mant_mem[it.index[IW-1:0]] <= it.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid && mode_t'(it.mode) == MODE_COMPUTE;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	// stage 2: table read (registered)
	logic [15:0] a_s2, b_s2;
	logic        last_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			ei_s1 <= ei_c;
			mi_s1 <= IW'(it.value[7:0] & MantIndexMask);
			last_s1 <= it.last;
			a_s2 <= exp_mem[ei_s1];
			b_s2 <= mant_mem[mi_s1];
			last_s2 <= last_s1;
		end
	end

	// stage 3: specials, multiply
	logic        nan_a, nan_b, inf_a, inf_b, z_a, z_b;
	logic [7:0]  sa, sb;
	logic signed [9:0] la, lb;
	always_comb begin
		nan_a = a_s2[14:7] == 8'hff && a_s2[6:0] != 7'd0;
		nan_b = b_s2[14:7] == 8'hff && b_s2[6:0] != 7'd0;
		inf_a = a_s2[14:0] == Bf16Inf[14:0];
		inf_b = b_s2[14:0] == Bf16Inf[14:0];
		z_a = a_s2[14:0] == 15'd0;
		z_b = b_s2[14:0] == 15'd0;
		sa = (a_s2[14:7] == 8'd0) ? {1'b0, a_s2[6:0]} : {1'b1, a_s2[6:0]};
		sb = (b_s2[14:7] == 8'd0) ? {1'b0, b_s2[6:0]} : {1'b1, b_s2[6:0]};
		la = (a_s2[14:7] == 8'd0) ? -10'sd133 : ($signed({2'b00, a_s2[14:7]}) - 10'sd134);
		lb = (b_s2[14:7] == 8'd0) ? -10'sd133 : ($signed({2'b00, b_s2[14:7]}) - 10'sd134);
	end

	logic [15:0] p_s3;
	logic signed [9:0] lsb_s3;
	logic        sign_s3, last_s3, spec_s3;
	logic [15:0] spec_val_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3 <= sa * sb;
			lsb_s3 <= la + lb;
			sign_s3 <= a_s2[15] ^ b_s2[15];
			last_s3 <= last_s2;
			spec_s3 <= nan_a || nan_b || inf_a || inf_b || z_a || z_b;
			if (nan_a || nan_b) spec_val_s3 <= Bf16Qnan;
			else if (inf_a || inf_b)
				spec_val_s3 <= (z_a || z_b) ? Bf16Qnan : {a_s2[15] ^ b_s2[15], Bf16Inf[14:0]};
			else spec_val_s3 <= {a_s2[15] ^ b_s2[15], 15'd0};
		end
	end

	// stage 4: normalise and round
	logic [3:0]  msb;
	logic signed [9:0] quant, shift;
	logic [15:0] q, rem, half;
	logic [16:0] enc;
	logic [15:0] res_c;
	always_comb begin
		msb = 4'd0;
		for (int k = 1; k < 16; k++) if (p_s3[k]) msb = 4'(k);
		quant = lsb_s3 + 10'($unsigned(msb)) - 10'sd7;
		if (quant < -10'sd133) quant = -10'sd133;
		shift = quant - lsb_s3;
		rem = '0; half = '0;
		if (shift <= 0) q = p_s3 << 4'(-shift);
		else if (shift > 10'sd16) q = '0;
		else begin
			rem  = p_s3 & ((16'd1 << 5'(shift)) - 16'd1);
			half = 16'd1 << 5'(shift - 10'sd1);
			q    = p_s3 >> 5'(shift);
			if (rem > half || (rem == half && q[0])) q = q + 16'd1;
		end
		enc = 17'(($unsigned(quant + 10'sd133)) << 7) + 17'(q);
		if (enc >= 17'(Bf16Inf)) enc = 17'(Bf16Inf);
		res_c = spec_s3 ? spec_val_s3 : {sign_s3, enc[14:0]};
	end

	out_item_t o_s4, o_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			o_s4 <= '{result: res_c, last_out: last_s3};
			o_s5 <= o_s4;
		end
	end

	assign out_ch.valid = v_s5;
	assign out_ch.data  = o_s5;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !out_ch.ready |=> v_s5 && $stable(o_s5))
		else $error("result changed while stalled");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s5 |-> in_ch.ready)
		else $error("pipe stalled with empty output");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.data.mode != MODE_COMPUTE |=> !v_s1)
		else $error("write produced a result");
endmodule
